### hw/rtl/cdq_pkg.sv
package cdq_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 11;

    // request codes
    localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
    localparam logic [1:0] REQ_PUSH_REAR  = 2'd1;
    localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
    localparam logic [1:0] REQ_POP_REAR   = 2'd3;

    // status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [DATA_W-1:0] push_value;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] pop_value;
    } rsp_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

### hw/rtl/cdq_mem.sv
module cdq_mem #(
    parameter int DEPTH = 1024
) (
    input  logic                         clk,
    input  cdq_pkg::mem_ctl_t            ctl,
    input  logic [$clog2(DEPTH)-1:0]     addr,
    input  logic [cdq_pkg::DATA_W-1:0]   wdata,
    output logic [cdq_pkg::DATA_W-1:0]   rdata
);

    localparam int AW = $clog2(DEPTH);

    logic [cdq_pkg::DATA_W-1:0] store_mem [DEPTH];
    logic [cdq_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            store_mem[addr[AW-1:0]] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= store_mem[addr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/cdq_ctrl.sv
module cdq_ctrl #(
    parameter int DEPTH = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  cdq_pkg::req_t                req,
    input  logic                         cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0]    cfg_wdata,
    output cdq_pkg::mem_ctl_t            mem_ctl,
    output logic [$clog2(DEPTH)-1:0]     mem_addr,
    output logic [cdq_pkg::DATA_W-1:0]   mem_wdata,
    input  logic [cdq_pkg::DATA_W-1:0]   mem_rdata,
    output logic                         done,
    output cdq_pkg::rsp_t                rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0] front_reg, front_next;
    logic [AW-1:0] rear_reg, rear_next;
    logic          empty_reg, empty_next;
    logic [CW-1:0] cap_reg, cap_next;
    logic          done_reg;
    logic [1:0]    status_reg, status_next;
    logic          pop_ok_reg, pop_ok_next;

    logic [AW-1:0] front_up, front_down, rear_up, rear_down;
    logic [CW-1:0] front_inc, rear_inc;
    logic          full;

    // wrap at the configured capacity
    assign front_inc  = CW'(front_reg) + CW'(1);
    assign rear_inc   = CW'(rear_reg) + CW'(1);
    assign front_up   = (front_inc >= cap_reg) ? '0 : AW'(front_inc);
    assign rear_up    = (rear_inc >= cap_reg) ? '0 : AW'(rear_inc);
    assign front_down = (front_reg == '0) ? AW'(cap_reg - CW'(1)) : front_reg - AW'(1);
    assign rear_down  = (rear_reg == '0) ? AW'(cap_reg - CW'(1)) : rear_reg - AW'(1);
    assign full       = (front_up == rear_reg);

    always_comb
    begin
        if (32'(cfg_wdata) > 32'(DEPTH))
        begin
            cap_next = CW'(DEPTH);
        end
        else if (cfg_wdata == '0)
        begin
            cap_next = CW'(1);
        end
        else
        begin
            cap_next = CW'(cfg_wdata);
        end
    end

    always_comb
    begin
        front_next    = front_reg;
        rear_next     = rear_reg;
        empty_next    = empty_reg;
        status_next   = cdq_pkg::ST_DONE;
        pop_ok_next   = 1'b0;
        mem_ctl.wr_en = 1'b0;
        mem_ctl.rd_en = 1'b0;
        mem_addr      = front_reg;
        mem_wdata     = req.push_value;
        if (start)
        begin
            case (req.req_type)
                cdq_pkg::REQ_PUSH_FRONT,
                cdq_pkg::REQ_PUSH_REAR:
                begin
                    if (empty_reg)
                    begin
                        front_next    = '0;
                        rear_next     = '0;
                        empty_next    = 1'b0;
                        mem_ctl.wr_en = 1'b1;
                        mem_addr      = '0;
                    end
                    else if (full)
                    begin
                        status_next = cdq_pkg::ST_OVERFLOW;
                    end
                    else if (req.req_type == cdq_pkg::REQ_PUSH_FRONT)
                    begin
                        front_next    = front_up;
                        mem_ctl.wr_en = 1'b1;
                        mem_addr      = front_up;
                    end
                    else
                    begin
                        rear_next     = rear_down;
                        mem_ctl.wr_en = 1'b1;
                        mem_addr      = rear_down;
                    end
                end
                cdq_pkg::REQ_POP_FRONT,
                cdq_pkg::REQ_POP_REAR:
                begin
                    if (empty_reg)
                    begin
                        status_next = cdq_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        pop_ok_next   = 1'b1;
                        mem_ctl.rd_en = 1'b1;
                        if (front_reg == rear_reg)
                        begin
                            empty_next = 1'b1;
                        end
                        if (req.req_type == cdq_pkg::REQ_POP_FRONT)
                        begin
                            mem_addr = front_reg;
                            if (front_reg != rear_reg)
                            begin
                                front_next = front_down;
                            end
                        end
                        else
                        begin
                            mem_addr = rear_reg;
                            if (front_reg != rear_reg)
                            begin
                                rear_next = rear_up;
                            end
                        end
                    end
                end
                default:
                begin
                    status_next = cdq_pkg::ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg  <= '0;
            rear_reg   <= '0;
            empty_reg  <= 1'b1;
            cap_reg    <= CW'(DEPTH);
            done_reg   <= 1'b0;
            status_reg <= cdq_pkg::ST_DONE;
            pop_ok_reg <= 1'b0;
        end
        else
        begin
            front_reg  <= front_next;
            rear_reg   <= rear_next;
            empty_reg  <= empty_next;
            done_reg   <= start;
            status_reg <= status_next;
            pop_ok_reg <= pop_ok_next;
            if (cfg_we)
            begin
                cap_reg <= cap_next;
            end
        end
    end

    assign done          = done_reg;
    assign rsp.status    = status_reg;
    assign rsp.pop_value = pop_ok_reg ? mem_rdata : '0;

endmodule

### hw/rtl/circular_deque.sv
// Circular deque of 32-bit words held in one single-port synchronous memory of
// DEPTH entries, of which the first "capacity" entries are in use (cfg_we /
// cfg_wdata; 0 acts as 1, values above DEPTH act as DEPTH). Pulse start with
// a request word on req: push front, push rear, pop front or pop rear. Every
// accepted request gives exactly one result word on rsp, marked by done for a
// single cycle, in the cycle after start. The block has no flow control on the
// result side: capture rsp whenever done is high, the word is gone next
// cycle. A request is taken every cycle, so busy never rises; the result word
// is registered, pop_value by the read port of the entry memory. A push to a
// full deque reports overflow and changes nothing, a pop from an empty deque
// reports underflow; pop_value is zero except for a successful pop. Each
// request touches at most one memory entry, and a write always lands before
// the next request reads, so no forwarding path is needed. Write capacity
// only while no request is in flight.
module circular_deque #(
    parameter int DEPTH = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  cdq_pkg::req_t               req,
    output logic                        done,
    output cdq_pkg::rsp_t               rsp,
    input  logic                        cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0]   cfg_wdata
);

    localparam int AW = $clog2(DEPTH);

    cdq_pkg::mem_ctl_t          mem_ctl;
    logic [AW-1:0]              mem_addr;
    logic [cdq_pkg::DATA_W-1:0] mem_wdata;
    logic [cdq_pkg::DATA_W-1:0] mem_rdata;

    // take a word every cycle
    assign busy = 1'b0;

    // index update, full/empty tracking and the result register
    cdq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .mem_ctl   (mem_ctl),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata),
        .done      (done),
        .rsp       (rsp)
    );

    // entry store, registered read
    cdq_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule
